// ----- rtl/lsovc_pkg.sv -----
`default_nettype none

package lsovc_pkg;

    // Fixed widths of the item fields on the stream ports.
    localparam int SEQ_FIELD_W  = 32;
    localparam int ADDR_FIELD_W = 48;

    // Bit positions inside the stored kind field.
    localparam int KIND_LOAD_BIT  = 0;
    localparam int KIND_STORE_BIT = 1;
    localparam int KIND_W         = 2;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXECUTE = 2'd1,
        CMD_REMOVE  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Result of comparing one stored entry against the current item.
    typedef struct packed {
        logic seq_eq;
        logic word_eq;
        logic younger;
        logic pc_ne;
        logic vseq_gt;
    } t_cmp_res;

endpackage

`default_nettype wire

// ----- rtl/lsovc_ram.sv -----
`default_nettype none

module lsovc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/lsovc_cmp.sv -----
`default_nettype none

module lsovc_cmp #(
    parameter int WORD_W = 45,
    parameter int SEQ_W  = 32,
    parameter int PC_W   = 48
) (
    input  wire logic [WORD_W-1:0] i_ent_word,
    input  wire logic [SEQ_W-1:0]  i_ent_seq,
    input  wire logic [PC_W-1:0]   i_ent_pc,
    input  wire logic [WORD_W-1:0] i_item_word,
    input  wire logic [SEQ_W-1:0]  i_item_seq,
    input  wire logic [PC_W-1:0]   i_item_pc,
    input  wire logic [SEQ_W-1:0]  i_best_seq,
    output lsovc_pkg::t_cmp_res    o_res
);

    import lsovc_pkg::*;

    always_comb begin
        o_res.seq_eq  = (i_ent_seq == i_item_seq);
        o_res.word_eq = (i_ent_word == i_item_word);
        o_res.younger = (i_ent_seq > i_item_seq);
        o_res.pc_ne   = (i_ent_pc != i_item_pc);
        o_res.vseq_gt = (i_ent_seq > i_best_seq);
    end

endmodule

`default_nettype wire

// ----- rtl/load_store_order_violation_check_top.sv -----
// Channel  | Direction | tdata                                  | tuser
// s_axis   | in        | seq_id, mem_addr, inst_pc              | cmd, is_load, is_store
// m_axis   | out       | violation, violating_seq, forwarded    | status
//
// Every item walks all ENTRIES slots through one compare unit, one slot per cycle,
// reading the slot payload from a RAM with registered read.
// The result is registered in the final step, and the input is ready again in the cycle in which
// the result becomes valid; no new item is taken while one is still being scanned.
// A result still waiting for m_axis_tready holds the next item in its final step.
// Reset clears the slot valid and done bits at once; there is no clearing pass.
`default_nettype none

module load_store_order_violation_check_top #(
    parameter int ENTRIES    = 32,
    parameter int WORD_SHIFT = 3,
    parameter int ADDR_BITS  = 48,
    parameter int SEQ_BITS   = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // seq_id, mem_addr, inst_pc
    input  wire logic [3:0]   s_axis_tuser,  // cmd, is_load, is_store
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata,  // violation, violating_seq, forwarded, zero fill
    output logic [1:0]        m_axis_tuser   // status
);

    import lsovc_pkg::*;

    localparam int ABITS = (ADDR_BITS < ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W;
    localparam int SW    = (SEQ_BITS < SEQ_FIELD_W) ? SEQ_BITS : SEQ_FIELD_W;
    localparam int WW    = ABITS - WORD_SHIFT;
    localparam int PW    = ABITS;
    localparam int DW    = WW + SW + PW + KIND_W;
    localparam int AW    = $clog2(ENTRIES);
    localparam int IW    = $clog2(ENTRIES + 1);

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_rd_v;
    logic [AW-1:0] r_rd_idx;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [ENTRIES-1:0] r_done, n_done;

    logic [1:0]    r_cmd, n_cmd;
    logic [SW-1:0] r_seq, n_seq;
    logic [WW-1:0] r_word, n_word;
    logic [PW-1:0] r_pc, n_pc;
    logic          r_ld, n_ld;
    logic          r_st, n_st;

    logic          r_self_found, n_self_found;
    logic [AW-1:0] r_self_idx, n_self_idx;
    logic          r_free_found, n_free_found;
    logic [AW-1:0] r_free_idx, n_free_idx;
    logic          r_viol, n_viol;
    logic [SW-1:0] r_vseq, n_vseq;
    logic          r_fwd, n_fwd;

    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    logic          r_out_viol, n_out_viol;
    logic [SW-1:0] r_out_vseq, n_out_vseq;
    logic          r_out_fwd, n_out_fwd;

    logic          ram_we;
    logic [DW-1:0] ram_wdata;
    logic [DW-1:0] ram_rdata;

    logic [WW-1:0]     ent_word;
    logic [SW-1:0]     ent_seq;
    logic [PW-1:0]     ent_pc;
    logic [KIND_W-1:0] ent_kind;
    logic              rd_valid;
    logic              rd_done;
    t_cmp_res          cmp;

    assign {ent_kind, ent_pc, ent_seq, ent_word} = ram_rdata;
    assign rd_valid = r_valid[r_rd_idx];
    assign rd_done  = r_done[r_rd_idx];
    assign ram_wdata = {r_st, r_ld, r_pc, r_seq, r_word};

    lsovc_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    lsovc_cmp #(
        .WORD_W (WW),
        .SEQ_W  (SW),
        .PC_W   (PW)
    ) u_cmp (
        .i_ent_word  (ent_word),
        .i_ent_seq   (ent_seq),
        .i_ent_pc    (ent_pc),
        .i_item_word (r_word),
        .i_item_seq  (r_seq),
        .i_item_pc   (r_pc),
        .i_best_seq  (r_vseq),
        .o_res       (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            r_rd_v      <= (r_state == S_SCAN) && (r_idx != IW'(ENTRIES));
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_rd_idx     <= r_idx[AW-1:0];
        r_cmd        <= n_cmd;
        r_seq        <= n_seq;
        r_word       <= n_word;
        r_pc         <= n_pc;
        r_ld         <= n_ld;
        r_st         <= n_st;
        r_self_found <= n_self_found;
        r_self_idx   <= n_self_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_viol       <= n_viol;
        r_vseq       <= n_vseq;
        r_fwd        <= n_fwd;
        r_out_status <= n_out_status;
        r_out_viol   <= n_out_viol;
        r_out_vseq   <= n_out_vseq;
        r_out_fwd    <= n_out_fwd;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_valid      = r_valid;
        n_done       = r_done;
        n_cmd        = r_cmd;
        n_seq        = r_seq;
        n_word       = r_word;
        n_pc         = r_pc;
        n_ld         = r_ld;
        n_st         = r_st;
        n_self_found = r_self_found;
        n_self_idx   = r_self_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_viol       = r_viol;
        n_vseq       = r_vseq;
        n_fwd        = r_fwd;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_viol   = r_out_viol;
        n_out_vseq   = r_out_vseq;
        n_out_fwd    = r_out_fwd;
        ram_we       = 1'b0;
        s_axis_tready = (r_state == S_IDLE);

        // One slot's RAM data arrives each cycle of the scan.
        if (r_rd_v) begin
            if (r_cmd == CMD_INSERT) begin
                if (!rd_valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_rd_idx;
                end
            end else if (rd_valid) begin
                // The lowest slot holding the sequence number is the item itself.
                if (cmp.seq_eq && !r_self_found) begin
                    n_self_found = 1'b1;
                    n_self_idx   = r_rd_idx;
                end else if (cmp.word_eq) begin
                    if (cmp.younger) begin
                        if (rd_done && cmp.pc_ne && r_st && ent_kind[KIND_LOAD_BIT] &&
                            (!r_viol || cmp.vseq_gt)) begin
                            n_viol = 1'b1;
                            n_vseq = ent_seq;
                        end
                    end else if (r_ld && ent_kind[KIND_STORE_BIT] && rd_done) begin
                        n_fwd = 1'b1;
                    end
                end
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd        = s_axis_tuser[1:0];
                    n_ld         = s_axis_tuser[2];
                    n_st         = s_axis_tuser[3];
                    n_seq        = s_axis_tdata[SW-1:0];
                    n_word       = s_axis_tdata[SEQ_FIELD_W+ABITS-1:SEQ_FIELD_W+WORD_SHIFT];
                    n_pc         = s_axis_tdata[SEQ_FIELD_W+ADDR_FIELD_W +: PW];
                    n_self_found = 1'b0;
                    n_free_found = 1'b0;
                    n_viol       = 1'b0;
                    n_vseq       = '0;
                    n_fwd        = 1'b0;
                    n_idx        = '0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx != IW'(ENTRIES)) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_viol   = 1'b0;
                    n_out_vseq   = '0;
                    n_out_fwd    = 1'b0;
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            if (r_free_found) begin
                                ram_we              = 1'b1;
                                n_valid[r_free_idx] = 1'b1;
                                n_done[r_free_idx]  = 1'b0;
                            end else begin
                                n_out_status = ST_FULL;
                            end
                        end
                        CMD_EXECUTE: begin
                            if (r_self_found) begin
                                n_done[r_self_idx] = 1'b1;
                                n_out_viol         = r_viol;
                                n_out_vseq         = r_vseq;
                                n_out_fwd          = r_fwd;
                            end else begin
                                n_out_status = ST_NOT_FOUND;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_self_found) begin
                                n_valid[r_self_idx] = 1'b0;
                                n_done[r_self_idx]  = 1'b0;
                            end else begin
                                n_out_status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            // The unused command code does nothing and reports all zero.
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {6'd0, r_out_fwd, SEQ_FIELD_W'(r_out_vseq), r_out_viol};

endmodule

`default_nettype wire

// ----- rtl/lsovc_chk.sv -----
`default_nettype none

module lsovc_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [127:0] s_axis_tdata,
    input wire logic [3:0]   s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [39:0]  m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser
);

    import lsovc_pkg::*;

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // A full queue or a missing entry reports no check results.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
        else $error("error status with nonzero result fields");

    // Without a violation the violating sequence number stays zero.
    a_vseq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == '0))
        else $error("violating sequence number without a violation");

endmodule

bind load_store_order_violation_check_top lsovc_chk u_lsovc_chk (.*);

`default_nettype wire

// ----- tb/lsovc_tb_pkg.sv -----
`timescale 1ns / 1ps

package lsovc_tb_pkg;

    import lsovc_pkg::*;

    localparam int LSQ_ENTRIES    = 32;
    localparam int LSQ_WORD_SHIFT = 3;
    localparam int WORD_W         = ADDR_FIELD_W - LSQ_WORD_SHIFT;

    // The cmd field is two bits wide; this code is decoded as no operation.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]             status;
        logic                   violation;
        logic [SEQ_FIELD_W-1:0] violating_seq;
        logic                   forwarded;
    } t_lsq_outcome;

    class disambig_scoreboard;

        bit                        slot_valid [LSQ_ENTRIES];
        bit                        slot_done  [LSQ_ENTRIES];
        logic [WORD_W-1:0]         slot_word  [LSQ_ENTRIES];
        logic [SEQ_FIELD_W-1:0]    slot_seq   [LSQ_ENTRIES];
        logic [ADDR_FIELD_W-1:0]   slot_pc    [LSQ_ENTRIES];
        logic [KIND_W-1:0]         slot_kind  [LSQ_ENTRIES];
        t_lsq_outcome              expected_outcomes [$];
        int                        mismatch_count;

        function new();
            foreach (slot_valid[i]) begin
                slot_valid[i] = 1'b0;
                slot_done[i]  = 1'b0;
            end
            mismatch_count = 0;
        endfunction

        function int find_slot(logic [SEQ_FIELD_W-1:0] seq);
            for (int i = 0; i < LSQ_ENTRIES; i++) begin
                if (slot_valid[i] && slot_seq[i] == seq) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (slot_valid[i]) begin
                if (slot_valid[i]) n++;
            end
            return n;
        endfunction

        function int pick_live_slot();
            int idx [$];
            foreach (slot_valid[i]) begin
                if (slot_valid[i]) idx.push_back(i);
            end
            if (idx.size() == 0) return -1;
            return idx[$urandom_range(0, idx.size() - 1)];
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        // Updates the queue image for one accepted transfer and stores its outcome.
        function void predict_outcome(logic [1:0] cmd, logic [SEQ_FIELD_W-1:0] seq,
                                      logic [ADDR_FIELD_W-1:0] addr,
                                      logic [ADDR_FIELD_W-1:0] pc, bit ld, bit st);
            t_lsq_outcome      res;
            logic [WORD_W-1:0] word;
            int                self;
            int                free_slot;
            res       = '0;
            word      = WORD_W'(addr >> LSQ_WORD_SHIFT);
            free_slot = -1;
            case (cmd)
                CMD_INSERT: begin
                    for (int i = LSQ_ENTRIES - 1; i >= 0; i--) begin
                        if (!slot_valid[i]) free_slot = i;
                    end
                    if (free_slot < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_valid[free_slot] = 1'b1;
                        slot_done[free_slot]  = 1'b0;
                        slot_word[free_slot]  = word;
                        slot_seq[free_slot]   = seq;
                        slot_pc[free_slot]    = pc;
                        slot_kind[free_slot]  = '0;
                        slot_kind[free_slot][KIND_LOAD_BIT]  = ld;
                        slot_kind[free_slot][KIND_STORE_BIT] = st;
                    end
                end
                CMD_EXECUTE: begin
                    self = find_slot(seq);
                    if (self < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        for (int i = 0; i < LSQ_ENTRIES; i++) begin
                            if (i == self || !slot_valid[i] || slot_word[i] != word) continue;
                            if (slot_seq[i] > seq) begin
                                // A younger load that already ran from another PC.
                                if (slot_done[i] && slot_pc[i] != pc && st &&
                                    slot_kind[i][KIND_LOAD_BIT]) begin
                                    if (!res.violation || slot_seq[i] > res.violating_seq)
                                        res.violating_seq = slot_seq[i];
                                    res.violation = 1'b1;
                                end
                            end else if (ld && slot_kind[i][KIND_STORE_BIT] && slot_done[i]) begin
                                res.forwarded = 1'b1;
                            end
                        end
                        slot_done[self] = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    self = find_slot(seq);
                    if (self < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        slot_valid[self] = 1'b0;
                        slot_done[self]  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            expected_outcomes.push_back(res);
        endfunction

        function void check_outcome(t_lsq_outcome got);
            t_lsq_outcome exp_res;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: result transfer with nothing expected: status %0d", $time,
                         got.status);
                mismatch_count++;
                return;
            end
            exp_res = expected_outcomes.pop_front();
            if (got.status !== exp_res.status) begin
                $display("%0t: status expected %0d, got %0d", $time, exp_res.status,
                         got.status);
                mismatch_count++;
            end
            if (got.violation !== exp_res.violation) begin
                $display("%0t: violation expected %0b, got %0b", $time, exp_res.violation,
                         got.violation);
                mismatch_count++;
            end
            if (got.violating_seq !== exp_res.violating_seq) begin
                $display("%0t: violating_seq expected %h, got %h", $time,
                         exp_res.violating_seq, got.violating_seq);
                mismatch_count++;
            end
            if (got.forwarded !== exp_res.forwarded) begin
                $display("%0t: forwarded expected %0b, got %0b", $time, exp_res.forwarded,
                         got.forwarded);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage

// ----- tb/load_store_order_violation_check_top_tb.sv -----
`timescale 1ns / 1ps

module load_store_order_violation_check_top_tb;

    import lsovc_pkg::*;
    import lsovc_tb_pkg::*;

    localparam int RANDOM_PER_PHASE = 517;
    localparam int HOLD_CYCLES      = 400;
    localparam int STALL_LIMIT      = 4000;
    localparam int TAIL_CYCLES      = 80;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;  // seq_id, mem_addr, inst_pc
    logic [3:0]   s_axis_tuser  = '0;  // cmd, is_load, is_store
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;        // violation, violating_seq, forwarded, zero fill
    logic [1:0]   m_axis_tuser;        // status

    disambig_scoreboard sb;

    int  send_idle_pct = 18;
    int  recv_idle_pct = 63;
    bit  hold_req      = 1'b0;
    int  hold_left     = 0;
    int  stall_cycles  = 0;

    logic [SEQ_FIELD_W-1:0]  seq_base;
    logic [ADDR_FIELD_W-1:0] addr_base;
    logic [ADDR_FIELD_W-1:0] pc_base;

    load_store_order_violation_check_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Receiver side: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_outcome({m_axis_tuser, m_axis_tdata[0], m_axis_tdata[32:1],
                              m_axis_tdata[33]});
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [SEQ_FIELD_W-1:0] seq,
                             input logic [ADDR_FIELD_W-1:0] addr,
                             input logic [ADDR_FIELD_W-1:0] pc, input bit ld, input bit st);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pc, addr, seq};
        s_axis_tuser  <= {st, ld, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.predict_outcome(cmd, seq, addr, pc, ld, st);
    endtask

    // Stops offering items until every outstanding result has been seen.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    function automatic logic [SEQ_FIELD_W-1:0] rand_seq();
        if ($urandom_range(0, 15) == 0) return $urandom;
        return seq_base + SEQ_FIELD_W'($urandom_range(0, 47));
    endfunction

    function automatic logic [ADDR_FIELD_W-1:0] rand_addr();
        if ($urandom_range(0, 15) == 0) return ADDR_FIELD_W'({$urandom, $urandom});
        return addr_base + ADDR_FIELD_W'($urandom_range(0, 3) * 8 + $urandom_range(0, 7));
    endfunction

    function automatic logic [ADDR_FIELD_W-1:0] rand_pc();
        if ($urandom_range(0, 15) == 0) return ADDR_FIELD_W'({$urandom, $urandom});
        return pc_base + ADDR_FIELD_W'($urandom_range(0, 3) * 4);
    endfunction

    // While filling, inserts dominate so the queue reaches full; otherwise removes
    // drain it back down. Executes mostly name a live entry and reuse its fields.
    task automatic send_random_item(input bit filling);
        int                      r;
        int                      k;
        int                      ins_end;
        int                      exe_end;
        logic [1:0]              cmd;
        logic [SEQ_FIELD_W-1:0]  seq;
        logic [ADDR_FIELD_W-1:0] addr;
        logic [ADDR_FIELD_W-1:0] pc;
        bit                      ld;
        bit                      st;
        ins_end = filling ? 45 : 12;
        exe_end = filling ? 85 : 62;
        r    = $urandom_range(0, 99);
        seq  = rand_seq();
        addr = rand_addr();
        pc   = rand_pc();
        ld   = 1'($urandom_range(0, 1));
        st   = 1'($urandom_range(0, 1));
        k    = -1;
        if (r < ins_end) begin
            cmd = CMD_INSERT;
        end else if (r < exe_end) begin
            cmd = CMD_EXECUTE;
            if ($urandom_range(0, 9) < 9) k = sb.pick_live_slot();
            if (k >= 0) begin
                seq  = sb.slot_seq[k];
                addr = (ADDR_FIELD_W'(sb.slot_word[k]) << LSQ_WORD_SHIFT) |
                       ADDR_FIELD_W'($urandom_range(0, (1 << LSQ_WORD_SHIFT) - 1));
                if ($urandom_range(0, 4) != 0) begin
                    pc = sb.slot_pc[k];
                    ld = sb.slot_kind[k][KIND_LOAD_BIT];
                    st = sb.slot_kind[k][KIND_STORE_BIT];
                end
            end
        end else if (r < 97) begin
            cmd = CMD_REMOVE;
            if ($urandom_range(0, 9) < 9) k = sb.pick_live_slot();
            if (k >= 0) seq = sb.slot_seq[k];
        end else begin
            cmd = (r < 99) ? CMD_UNUSED : CMD_EXECUTE;
        end
        send_item(cmd, seq, addr, pc, ld, st);
    endtask

    initial begin
        sb = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, ordering violation, forwarding, duplicates and misses.
        send_item(CMD_INSERT,  32'd0,  48'd0,     48'd0,    1'b1, 1'b0);
        send_item(CMD_INSERT,  '1,     '1,        '1,       1'b1, 1'b1);
        send_item(CMD_INSERT,  32'd10, 48'h100,   48'h40,   1'b0, 1'b1);
        send_item(CMD_INSERT,  32'd20, 48'h104,   48'h44,   1'b1, 1'b0);
        send_item(CMD_INSERT,  32'd30, 48'h107,   48'h48,   1'b1, 1'b0);
        send_item(CMD_EXECUTE, 32'd20, 48'h104,   48'h44,   1'b1, 1'b0);
        send_item(CMD_EXECUTE, 32'd30, 48'h107,   48'h48,   1'b1, 1'b0);
        send_item(CMD_EXECUTE, 32'd10, 48'h100,   48'h40,   1'b0, 1'b1);
        send_item(CMD_INSERT,  32'd40, 48'h102,   48'h40,   1'b1, 1'b0);
        send_item(CMD_EXECUTE, 32'd40, 48'h102,   48'h40,   1'b1, 1'b0);
        // Re-executing a done store; the load with the same PC does not count.
        send_item(CMD_EXECUTE, 32'd10, 48'h100,   48'h40,   1'b0, 1'b1);
        send_item(CMD_INSERT,  32'd20, 48'h100,   48'h50,   1'b0, 1'b1);
        send_item(CMD_EXECUTE, 32'd20, 48'h100,   48'h60,   1'b1, 1'b1);
        send_item(CMD_EXECUTE, 32'd99, 48'h100,   48'h60,   1'b1, 1'b1);
        send_item(CMD_REMOVE,  32'd77, 48'd0,     48'd0,    1'b0, 1'b0);
        send_item(CMD_UNUSED,  '1,     '1,        '1,       1'b1, 1'b1);
        send_item(CMD_REMOVE,  32'd20, 48'd0,     48'd0,    1'b0, 1'b0);
        send_item(CMD_EXECUTE, 32'd20, 48'h105,   48'h50,   1'b0, 1'b1);
        send_item(CMD_EXECUTE, '1,     '1,        '1,       1'b1, 1'b1);
        send_item(CMD_EXECUTE, 32'd0,  48'd0,     48'd0,    1'b1, 1'b0);
        send_item(CMD_EXECUTE, 32'd10, 48'h100,   48'h40,   1'b0, 1'b0);
        send_item(CMD_REMOVE,  32'd10, 48'd0,     48'd0,    1'b0, 1'b0);
        send_item(CMD_REMOVE,  32'd20, 48'd0,     48'd0,    1'b0, 1'b0);
        send_item(CMD_REMOVE,  32'd30, 48'd0,     48'd0,    1'b0, 1'b0);
        send_item(CMD_REMOVE,  32'd40, 48'd0,     48'd0,    1'b0, 1'b0);
        drain_results();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            seq_base  = $urandom;
            addr_base = ADDR_FIELD_W'({$urandom, $urandom});
            pc_base   = ADDR_FIELD_W'({$urandom, $urandom});
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (ph == 0 && n == 120) hold_req = 1'b1;
                if (ph == 1 && n == 200) drain_results();
                send_random_item(((n / 100) % 2) == 0);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lsovc_pkg.sv
rtl/lsovc_ram.sv
rtl/lsovc_cmp.sv
rtl/load_store_order_violation_check_top.sv
rtl/lsovc_chk.sv
tb/lsovc_tb_pkg.sv
tb/load_store_order_violation_check_top_tb.sv
